// ===== sv/mpcs_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mpcs_pkg
// Shared types and fixed widths for the minimum partition capacity search.
// ----------------------------------------------------------------------------
package mpcs_pkg;

  // Width of the saturating weight sum and of the emitted capacity.
  localparam int unsigned SUM_W = 26;
  // Width of the day limit register.
  localparam int unsigned DAY_W = 11;

  localparam logic [SUM_W-1:0] SUM_LIMIT = {SUM_W{1'b1}};
  localparam logic [DAY_W-1:0] DAY_RESET = DAY_W'(1);

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_INIT,
    ST_START,
    ST_RUN,
    ST_FINISH
  } state_e;

endpackage : mpcs_pkg
`default_nettype wire

// ===== sv/mpcs_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mpcs_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module mpcs_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule : mpcs_ram
`default_nettype wire

// ===== sv/min_partition_capacity_search_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// min_partition_capacity_search_top
// Loads a set of weights into a RAM, then binary-searches the smallest
// group capacity that splits the set into at most day_limit groups.
// ----------------------------------------------------------------------------
//
//  Channel | Direction | Handshake                | Payload
//  --------+-----------+--------------------------+---------------------------
//  input   | in        | in_valid_i / in_ready_o  | weight_i, last_i
//  result  | out       | out_valid_o / out_ready_i| min_capacity_o, overflow_o
//  config  | in        | cfg_valid_i / cfg_ready_o| cfg_data_i (day_limit)
//
// Weights are accepted one per cycle while loading and written to the weight
// RAM at their accept edge unless the store is full. After the transaction
// marked last, a binary search runs P probes (at most 26); each probe streams
// the N stored weights through the single RAM read port, one per cycle.
// No clearing pass is needed after reset. in_ready_o is low during the search
// and until the result register is free; cfg_ready_o is always high.
//
module min_partition_capacity_search_top #(
  parameter int unsigned MAX_ITEMS   = 1024,
  parameter int unsigned WEIGHT_BITS = 16
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  // Item channel.
  input  wire logic                       in_valid_i,
  output logic                            in_ready_o,
  input  wire logic [WEIGHT_BITS-1:0]     weight_i,
  input  wire logic                       last_i,
  // Result channel.
  output logic                            out_valid_o,
  input  wire logic                       out_ready_i,
  output logic [mpcs_pkg::SUM_W-1:0]      min_capacity_o,
  output logic                            overflow_o,
  // Configuration channel.
  input  wire logic                       cfg_valid_i,
  output logic                            cfg_ready_o,
  input  wire logic [mpcs_pkg::DAY_W-1:0] cfg_data_i
);

  import mpcs_pkg::*;

  // Address width of the weight RAM and width of a counter that can hold
  // the full item count.
  localparam int unsigned AW    = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_ITEMS + 1);
  // Capacity values must hold both the saturated sum and a single weight.
  localparam int unsigned VW    = (WEIGHT_BITS > SUM_W) ? WEIGHT_BITS : SUM_W;
  localparam int unsigned TW    = VW + 1;
  // The group count never exceeds the item count.
  localparam int unsigned DW    = CNT_W + 1;
  localparam int unsigned CW    = (DW > DAY_W) ? DW : DAY_W;

  state_e state_q, state_d;

  logic [DAY_W-1:0]       day_limit_q;
  logic [CNT_W-1:0]       count_q, count_d;
  logic [WEIGHT_BITS-1:0] max_q, max_d;
  logic [SUM_W-1:0]       total_q, total_d;
  logic                   ovf_q, ovf_d;
  logic [VW-1:0]          low_q, low_d;
  logic [VW-1:0]          high_q, high_d;
  logic [VW-1:0]          mid_q, mid_d;
  logic [VW-1:0]          load_q, load_d;
  logic [DW-1:0]          days_q, days_d;
  logic [CNT_W-1:0]       idx_q, idx_d;
  logic                   rvalid_q, rvalid_d;
  logic                   out_valid_q, out_valid_d;
  logic [SUM_W-1:0]       res_cap_q, res_cap_d;
  logic                   res_ovf_q, res_ovf_d;

  logic                   in_accept;
  logic                   store_full;
  logic                   wr_en;
  logic                   rd_en;
  logic [WEIGHT_BITS-1:0] rd_data;
  logic [TW-1:0]          tot_sum;
  logic [TW-1:0]          mid_sum;
  logic [TW-1:0]          grp_sum;

  assign in_ready_o  = (state_q == ST_LOAD);
  assign cfg_ready_o = 1'b1;
  assign in_accept   = in_valid_i && in_ready_o;
  assign store_full  = (count_q == CNT_W'(MAX_ITEMS));
  // An item that finds the store full is dropped and only flagged.
  assign wr_en       = in_accept && !store_full;

  assign tot_sum = TW'(total_q) + TW'(weight_i);
  assign mid_sum = {1'b0, low_q} + {1'b0, high_q};
  assign grp_sum = {1'b0, load_q} + TW'(rd_data);

  // The last item is written at its accept edge, and the first probe read is
  // issued only after the ST_INIT and ST_START states, so reads and writes never collide.
  mpcs_ram #(
    .WIDTH (WEIGHT_BITS),
    .DEPTH (MAX_ITEMS)
  ) u_weight_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (count_q[AW-1:0]),
    .wdata_i (weight_i),
    .re_i    (rd_en),
    .raddr_i (idx_q[AW-1:0]),
    .rdata_o (rd_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_LOAD;
      day_limit_q <= DAY_RESET;
      count_q     <= '0;
      max_q       <= '0;
      total_q     <= '0;
      ovf_q       <= 1'b0;
      low_q       <= '0;
      high_q      <= '0;
      mid_q       <= '0;
      load_q      <= '0;
      days_q      <= '0;
      idx_q       <= '0;
      rvalid_q    <= 1'b0;
      out_valid_q <= 1'b0;
      res_cap_q   <= '0;
      res_ovf_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      if (cfg_valid_i) begin
        day_limit_q <= cfg_data_i;
      end
      count_q     <= count_d;
      max_q       <= max_d;
      total_q     <= total_d;
      ovf_q       <= ovf_d;
      low_q       <= low_d;
      high_q      <= high_d;
      mid_q       <= mid_d;
      load_q      <= load_d;
      days_q      <= days_d;
      idx_q       <= idx_d;
      rvalid_q    <= rvalid_d;
      out_valid_q <= out_valid_d;
      res_cap_q   <= res_cap_d;
      res_ovf_q   <= res_ovf_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    max_d       = max_q;
    total_d     = total_q;
    ovf_d       = ovf_q;
    low_d       = low_q;
    high_d      = high_q;
    mid_d       = mid_q;
    load_d      = load_q;
    days_d      = days_q;
    idx_d       = idx_q;
    rvalid_d    = rvalid_q;
    out_valid_d = out_valid_q;
    res_cap_d   = res_cap_q;
    res_ovf_d   = res_ovf_q;
    rd_en       = 1'b0;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_LOAD: begin
        if (in_accept) begin
          if (!store_full) begin
            count_d = count_q + CNT_W'(1);
            if (weight_i > max_q) begin
              max_d = weight_i;
            end
            if (tot_sum > TW'(SUM_LIMIT)) begin
              total_d = SUM_LIMIT;
            end else begin
              total_d = tot_sum[SUM_W-1:0];
            end
          end else begin
            ovf_d = 1'b1;
          end
          if (last_i) begin
            state_d = ST_INIT;
          end
        end
      end

      ST_INIT: begin
        low_d   = VW'(max_q);
        high_d  = VW'(total_q);
        state_d = ST_START;
      end

      ST_START: begin
        if (low_q < high_q) begin
          mid_d    = mid_sum[VW:1];
          days_d   = DW'(1);
          load_d   = '0;
          idx_d    = '0;
          rvalid_d = 1'b0;
          state_d  = ST_RUN;
        end else begin
          state_d = ST_FINISH;
        end
      end

      ST_RUN: begin
        // Issue one read per cycle while items remain; the data is consumed in the following cycle.
        if (idx_q < count_q) begin
          rd_en    = 1'b1;
          idx_d    = idx_q + CNT_W'(1);
          rvalid_d = 1'b1;
        end else begin
          rvalid_d = 1'b0;
        end

        if (rvalid_q) begin
          if (grp_sum > {1'b0, mid_q}) begin
            days_d = days_q + DW'(1);
            load_d = VW'(rd_data);
          end else begin
            load_d = grp_sum[VW-1:0];
          end
        end else if (!(idx_q < count_q)) begin
          // The greedy pass is complete: narrow the search range.
          if (CW'(days_q) <= CW'(day_limit_q)) begin
            high_d = mid_q;
          end else begin
            low_d = mid_q + VW'(1);
          end
          state_d = ST_START;
        end
      end

      ST_FINISH: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          res_cap_d   = low_q[SUM_W-1:0];
          res_ovf_d   = ovf_q;
          count_d     = '0;
          max_d       = '0;
          total_d     = '0;
          ovf_d       = 1'b0;
          state_d     = ST_LOAD;
        end
      end

      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

  assign out_valid_o    = out_valid_q;
  assign min_capacity_o = res_cap_q;
  assign overflow_o     = res_ovf_q;

endmodule : min_partition_capacity_search_top
`default_nettype wire
